@@ rtl/core/vector_store_topk_search_macros.svh @@
// Assertion macros for the vector store RTL.
`ifndef VECTOR_STORE_TOPK_SEARCH_MACROS_SVH
`define VECTOR_STORE_TOPK_SEARCH_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define VS_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define VS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/core/vst_pkg.sv @@
// Shared types and constants for the vector store top-k search block.
package vst_pkg;
    localparam int MaxDocs  = 1024;
    localparam int TopK     = 8;
    localparam int AddrW    = $clog2(MaxDocs);
    localparam int CountW   = $clog2(MaxDocs + 1);
    localparam int CompW    = 17;
    localparam int DistW    = 35;
    localparam int KeyW     = 32;
    localparam int RankW    = 3;
    localparam int HitW     = 4;
    localparam int NComp    = 7;
    localparam logic [CompW-1:0] OneQ16 = 17'd65536;
    localparam logic [DistW-1:0] ThreshReset = 35'd30064771072;

    typedef enum logic [1:0] {
        OP_INDEX  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef logic [NComp-1:0][CompW-1:0] t_vec;

    // Classified command handed from the front end to the engine
    typedef struct packed {
        t_op              op;
        logic [KeyW-1:0]  key;
        t_vec             vec;
        logic [HitW-1:0]  limit;
    } t_cmd;

    function automatic logic [CompW-1:0] sat_comp(input logic [CompW-1:0] c);
        sat_comp = (c > OneQ16) ? OneQ16 : c;
    endfunction
endpackage

@@ rtl/core/vst_front.sv @@
// Front end: accepts items, saturates components, clips hit count, queues commands.
module vst_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_operation,
    input  logic [31:0]    i_entry_key,
    input  vst_pkg::t_vec  i_vec,
    input  logic [3:0]     i_wanted_hits,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output vst_pkg::t_cmd  o_cmd
);
    import vst_pkg::*;

    // two-entry queue
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push, pop;

    always_comb begin
        n_cmd.op  = t_op'(i_operation);
        n_cmd.key = i_entry_key;
        for (int k = 0; k < NComp; k++) begin
            n_cmd.vec[k] = sat_comp(i_vec[k]);
        end
        n_cmd.limit = (i_wanted_hits > HitW'(TopK)) ? HitW'(TopK) : i_wanted_hits;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

@@ rtl/core/vst_engine.sv @@
// Back end: entry memories, key scan, distance pipeline, top-k insertion, result output.
`include "vector_store_topk_search_macros.svh"
module vst_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  vst_pkg::t_cmd                i_cmd,
    input  logic [vst_pkg::DistW-1:0]    i_threshold,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [31:0]                  o_hit_key,
    output logic [34:0]                  o_hit_distance,
    output logic [2:0]                   o_hit_rank,
    output logic                         o_last
);
    import vst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_MOVE, S_MOVE2, S_EMIT, S_WAIT
    } t_state;

    localparam int PipeD = 4; // read, diff, square, sum

    logic [KeyW-1:0]            mem_key [MaxDocs];
    logic [NComp*CompW-1:0]     mem_vec [MaxDocs];

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [CountW-1:0]    r_count;
    logic [CountW-1:0]    r_idx;
    logic [AddrW-1:0]     r_found_at;
    logic                 r_found;
    logic [AddrW-1:0]     r_rd_addr;
    logic                 r_rd_en;
    logic [KeyW-1:0]      r_rd_key;
    logic [NComp*CompW-1:0] r_rd_vec;
    // pipeline valid and address tags
    logic [PipeD-1:0]     r_pv;
    logic [AddrW-1:0]     r_pa1;
    logic [KeyW-1:0]      r_k2, r_k3;
    logic [NComp-1:0][CompW-1:0] r_diff;
    logic [NComp-1:0][2*CompW-1:0] r_sq;
    logic [DistW-1:0]     r_dist;
    logic [KeyW-1:0]      r_k4;
    logic                 r_hit4;
    logic [KeyW-1:0]      r_bkey  [TopK];
    logic [DistW-1:0]     r_bdist [TopK];
    logic [HitW-1:0]      r_bcnt;
    logic [HitW-1:0]      r_emit;
    logic                 r_ov;
    logic [1:0]           r_ost;
    logic [KeyW-1:0]      r_okey;
    logic [DistW-1:0]     r_odist;
    logic [RankW-1:0]     r_orank;
    logic                 r_olast;
    logic [AddrW-1:0]     r_mv_dst;

    logic                 out_free;
    logic [DistW-1:0]     sum_d;

    assign out_free    = !r_ov || i_ready;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid        = r_ov;
    assign o_status       = r_ost;
    assign o_hit_key      = r_okey;
    assign o_hit_distance = r_odist;
    assign o_hit_rank     = r_orank;
    assign o_last         = r_olast;

    always_comb begin
        sum_d = '0;
        for (int k = 0; k < NComp; k++) begin
            sum_d = sum_d + DistW'(r_sq[k]);
        end
    end

    // memory: one write port, one registered read port
    logic                 mem_we;
    logic [AddrW-1:0]     mem_wa;
    logic [KeyW-1:0]      mem_wk;
    logic [NComp*CompW-1:0] mem_wv;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_key[mem_wa] <= mem_wk;
            mem_vec[mem_wa] <= mem_wv;
        end
        if (r_rd_en) begin
            r_rd_key <= mem_key[r_rd_addr];
            r_rd_vec <= mem_vec[r_rd_addr];
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_pa1 <= r_rd_addr;
        r_k2  <= r_rd_key;
        for (int k = 0; k < NComp; k++) begin
            logic [CompW-1:0] e;
            e = r_rd_vec[k*CompW +: CompW];
            r_diff[k] <= (r_cmd.vec[k] > e) ? r_cmd.vec[k] - e : e - r_cmd.vec[k];
            r_sq[k]   <= r_diff[k] * r_diff[k];
        end
        r_k3   <= r_k2;
        r_dist <= sum_d;
        r_k4   <= r_k3;
    end

    // top-k insertion: each slot decides locally; ties keep earlier entries first
    logic [TopK-1:0] lt;
    logic            ins;
    always_comb begin
        for (int j = 0; j < TopK; j++) begin
            lt[j] = (HitW'(j) < r_bcnt) && (r_dist < r_bdist[j]);
        end
        ins = r_pv[3] && r_hit4 &&
              ((r_bcnt < r_cmd.limit) ||
               (r_dist < r_bdist[RankW'(r_cmd.limit - HitW'(1))]));
    end

    always_ff @(posedge i_clk) begin
        if (ins) begin
            for (int j = 0; j < TopK; j++) begin
                if (lt[j]) begin
                    if (j == 0 || !lt[(j == 0) ? 0 : j-1]) begin
                        r_bkey[j]  <= r_k4;
                        r_bdist[j] <= r_dist;
                    end else begin
                        r_bkey[j]  <= r_bkey[(j == 0) ? 0 : j-1];
                        r_bdist[j] <= r_bdist[(j == 0) ? 0 : j-1];
                    end
                end else if (HitW'(j) == r_bcnt) begin
                    if (j != 0 && lt[(j == 0) ? 0 : j-1]) begin
                        r_bkey[j]  <= r_bkey[(j == 0) ? 0 : j-1];
                        r_bdist[j] <= r_bdist[(j == 0) ? 0 : j-1];
                    end else begin
                        r_bkey[j]  <= r_k4;
                        r_bdist[j] <= r_dist;
                    end
                end
            end
        end
    end

    logic match_now;
    assign match_now = r_pv[0] && (r_rd_key == r_cmd.key) && !r_found;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_found_at;
        mem_wk = r_cmd.key;
        mem_wv = r_cmd.vec;
        if (r_state == S_DRAIN && r_cmd.op == OP_INDEX && out_free && r_pv == '0) begin
            if (r_found) begin
                mem_we = 1'b1;
            end else if (r_count < CountW'(MaxDocs)) begin
                mem_we = 1'b1;
                mem_wa = r_count[AddrW-1:0];
            end
        end else if (r_state == S_MOVE2) begin
            mem_we = 1'b1;
            mem_wa = r_mv_dst;
            mem_wk = r_rd_key;
            mem_wv = r_rd_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pv    <= '0;
            r_rd_en <= 1'b0;
            r_bcnt  <= '0;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            r_hit4 <= (sum_d <= i_threshold);
            r_pv   <= {r_pv[PipeD-2:0], r_rd_en};
            if (ins) begin
                r_bcnt <= (r_bcnt < r_cmd.limit) ? r_bcnt + HitW'(1) : r_bcnt;
            end
            if (match_now) begin
                r_found    <= 1'b1;
                r_found_at <= r_pa1;
            end
            r_rd_en <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_bcnt  <= '0;
                        r_state <= (i_cmd.op == OP_NONE ||
                                    (i_cmd.op == OP_SEARCH && i_cmd.limit == '0))
                                   ? S_DRAIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_count) begin
                        r_rd_en   <= 1'b1;
                        r_rd_addr <= r_idx[AddrW-1:0];
                        r_idx     <= r_idx + CountW'(1);
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_pv == '0 && !r_rd_en && out_free) begin
                        r_ost   <= ST_DONE;
                        r_okey  <= '0;
                        r_odist <= '0;
                        r_orank <= '0;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                        case (r_cmd.op)
                            OP_INDEX: begin
                                r_ov <= 1'b1;
                                if (!r_found) begin
                                    if (r_count < CountW'(MaxDocs)) begin
                                        r_count <= r_count + CountW'(1);
                                    end else begin
                                        r_ost <= ST_FULL;
                                    end
                                end
                            end
                            OP_REMOVE: begin
                                if (!r_found) begin
                                    r_ost <= ST_NOTFOUND;
                                    r_ov  <= 1'b1;
                                end else begin
                                    r_rd_en   <= 1'b1;
                                    r_rd_addr <= AddrW'(r_count - CountW'(1));
                                    r_mv_dst  <= r_found_at;
                                    r_state   <= S_MOVE;
                                end
                            end
                            OP_SEARCH: begin
                                if (r_bcnt == '0) begin
                                    r_ost <= ST_EMPTY;
                                    r_ov  <= 1'b1;
                                end else begin
                                    r_emit  <= '0;
                                    r_state <= S_EMIT;
                                end
                            end
                            default: r_ov <= 1'b1;
                        endcase
                    end
                end
                S_MOVE: r_state <= S_MOVE2;
                S_MOVE2: begin
                    r_count <= r_count - CountW'(1);
                    r_pv    <= '0;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_ost   <= ST_DONE;
                        r_okey  <= '0;
                        r_odist <= '0;
                        r_orank <= '0;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_ost   <= ST_DONE;
                        r_okey  <= r_bkey[r_emit[RankW-1:0]];
                        r_odist <= r_bdist[r_emit[RankW-1:0]];
                        r_orank <= r_emit[RankW-1:0];
                        r_olast <= (r_emit + HitW'(1) == r_bcnt);
                        r_emit  <= r_emit + HitW'(1);
                        if (r_emit + HitW'(1) == r_bcnt) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `VS_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CountW'(MaxDocs), "count overflow")
    `VS_ASSERT_IMPL(a_bcnt_range, i_clk, i_rst_n, 1'b1, r_bcnt <= HitW'(TopK), "best count overflow")
    `VS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_okey), "result dropped")
    `VS_ASSERT_IMPL(a_nohit_zero, i_clk, i_rst_n, r_ov && r_ost != ST_DONE, r_okey == '0 && r_olast, "bad non-hit item")
endmodule

@@ rtl/core/vector_store_topk_search.sv @@
// The engine takes one item at a time and scans every stored entry before it gives the first result;
// a no-op and a search for zero hits skip the scan.
// A two-entry command queue lets new items be accepted while the engine is busy.
// Synchronous active-low reset empties the store and sets the threshold to its default.
// Top level of the vector store top-k search block.
module vector_store_topk_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_entry_key,
    input  logic [16:0] i_comp_x,
    input  logic [16:0] i_comp_y,
    input  logic [16:0] i_comp_z,
    input  logic [16:0] i_comp_w,
    input  logic [16:0] i_comp_v,
    input  logic [16:0] i_comp_u,
    input  logic [16:0] i_comp_t,
    input  logic [3:0]  i_wanted_hits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [34:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_hit_key,
    output logic [34:0] o_hit_distance,
    output logic [2:0]  o_hit_rank,
    output logic        o_last
);
    import vst_pkg::*;

    logic [DistW-1:0] r_threshold;
    t_vec             in_vec;
    t_cmd             cmd;
    logic             cmd_valid, cmd_ready;

    assign in_vec = {i_comp_t, i_comp_u, i_comp_v, i_comp_w, i_comp_z, i_comp_y, i_comp_x};
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ThreshReset;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    vst_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_operation, .i_entry_key,
        .i_vec(in_vec), .i_wanted_hits,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    vst_engine u_engine (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_cmd(cmd), .i_threshold(r_threshold),
        .o_valid, .i_ready, .o_status, .o_hit_key, .o_hit_distance,
        .o_hit_rank, .o_last
    );
endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the vector store top-k search block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vst_pkg::*;

    typedef struct {
        t_op              op;
        logic [31:0]      key;
        logic [16:0]      comp [7];
        logic [3:0]       hits;
    } t_item;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] key;
        logic [34:0] hit_dist;
        logic [2:0]  rank;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = '0;
    logic [31:0] i_entry_key = '0;
    logic [16:0] i_comp_x = '0, i_comp_y = '0, i_comp_z = '0, i_comp_w = '0;
    logic [16:0] i_comp_v = '0, i_comp_u = '0, i_comp_t = '0;
    logic [3:0]  i_wanted_hits = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [34:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_hit_key;
    logic [34:0] o_hit_distance;
    logic [2:0]  o_hit_rank;
    logic        o_last;

    vector_store_topk_search dut (.*);

    always #1 i_clk = ~i_clk;

    // shadow of the block state
    logic [31:0] shadow_keys [MaxDocs];
    logic [16:0] shadow_vecs [MaxDocs][7];
    int          shadow_count = 0;
    logic [34:0] shadow_thresh = ThreshReset;

    t_item   pending_items [$];
    t_result expected_results [$];
    int      errors = 0;
    int      n_results = 0;
    int      n_hits = 0;
    int      gap_left = 0;
    int      burst_left = 0;
    int      stall_phase = 0;
    logic    o_ready_q = 1'b0;

    function automatic int find_entry(logic [31:0] key);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_keys[i] == key) return i;
        return -1;
    endfunction

    function automatic t_result make_result(logic [1:0] st, logic [31:0] k,
                                            logic [34:0] d, int r, bit l);
        t_result res;
        res.status = st; res.key = k; res.hit_dist = d; res.rank = r[2:0]; res.last = l;
        return res;
    endfunction

    // apply one accepted item to the shadow state and queue its results
    task automatic predict_item(t_item it);
        logic [16:0] q [7];
        logic [34:0] best_d [8];
        logic [31:0] best_k [8];
        logic [34:0] d;
        logic [17:0] diff;
        int at, limit, nbest, j;
        for (int c = 0; c < 7; c++) q[c] = (it.comp[c] > OneQ16) ? OneQ16 : it.comp[c];
        case (it.op)
            OP_INDEX: begin
                at = find_entry(it.key);
                if (at < 0 && shadow_count >= MaxDocs) begin
                    expected_results.push_back(make_result(ST_FULL, 0, 0, 0, 1));
                end else begin
                    if (at < 0) begin
                        at = shadow_count;
                        shadow_count++;
                    end
                    shadow_keys[at] = it.key;
                    for (int c = 0; c < 7; c++) shadow_vecs[at][c] = q[c];
                    expected_results.push_back(make_result(ST_DONE, 0, 0, 0, 1));
                end
            end
            OP_REMOVE: begin
                at = find_entry(it.key);
                if (at < 0) begin
                    expected_results.push_back(make_result(ST_NOTFOUND, 0, 0, 0, 1));
                end else begin
                    shadow_keys[at] = shadow_keys[shadow_count-1];
                    for (int c = 0; c < 7; c++) shadow_vecs[at][c] = shadow_vecs[shadow_count-1][c];
                    shadow_count--;
                    expected_results.push_back(make_result(ST_DONE, 0, 0, 0, 1));
                end
            end
            OP_SEARCH: begin
                limit = (it.hits > TopK) ? TopK : it.hits;
                nbest = 0;
                for (int i = 0; i < shadow_count && limit > 0; i++) begin
                    d = '0;
                    for (int c = 0; c < 7; c++) begin
                        diff = (q[c] > shadow_vecs[i][c]) ? q[c] - shadow_vecs[i][c]
                                                          : shadow_vecs[i][c] - q[c];
                        d += 35'(diff) * 35'(diff);
                    end
                    if (d > shadow_thresh) continue;
                    // strict compare keeps earlier entries ahead on ties
                    if (nbest == limit) begin
                        if (d >= best_d[limit-1]) continue;
                        nbest--;
                    end
                    j = nbest;
                    while (j > 0 && d < best_d[j-1]) begin
                        best_d[j] = best_d[j-1];
                        best_k[j] = best_k[j-1];
                        j--;
                    end
                    best_d[j] = d;
                    best_k[j] = shadow_keys[i];
                    nbest++;
                end
                if (nbest == 0)
                    expected_results.push_back(make_result(ST_EMPTY, 0, 0, 0, 1));
                for (int i = 0; i < nbest; i++)
                    expected_results.push_back(make_result(ST_DONE, best_k[i], best_d[i], i,
                                                           i == nbest - 1));
            end
            default: expected_results.push_back(make_result(ST_DONE, 0, 0, 0, 1));
        endcase
    endtask

    function automatic t_item rand_item(t_op op, int nkeys);
        t_item it;
        it.op = op;
        it.key = (nkeys > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, nkeys - 1)
                                                         : $urandom;
        for (int c = 0; c < 7; c++)
            case ($urandom_range(0, 5))
                0: it.comp[c] = 17'd0;
                1: it.comp[c] = OneQ16;
                2: it.comp[c] = 17'($urandom);  // may exceed one
                default: it.comp[c] = 17'($urandom_range(0, 65536));
            endcase
        it.hits = 4'($urandom);
        return it;
    endfunction

    task automatic queue_item(t_op op, logic [31:0] key, logic [16:0] v, logic [3:0] hits);
        t_item it;
        it.op = op; it.key = key; it.hits = hits;
        for (int c = 0; c < 7; c++) it.comp[c] = v;
        pending_items.push_back(it);
    endtask

    // wait for every queued item and result, then for the engine to settle
    task automatic drain();
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (shadow_count + 40) @(posedge i_clk);
    endtask

    task automatic write_thresh(logic [34:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_thresh = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // driver: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !o_ready_q)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                t_item it;
                it = pending_items.pop_front();
                i_valid       <= 1'b1;
                i_operation   <= it.op;
                i_entry_key   <= it.key;
                i_comp_x <= it.comp[0]; i_comp_y <= it.comp[1]; i_comp_z <= it.comp[2];
                i_comp_w <= it.comp[3]; i_comp_v <= it.comp[4]; i_comp_u <= it.comp[5];
                i_comp_t <= it.comp[6];
                i_wanted_hits <= it.hits;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 6);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
        // receiver stall pattern: runs of ready, runs of stall
        stall_phase++;
        if (stall_phase[5]) i_ready <= 1'b1;
        else i_ready <= (stall_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
    end

    // accepted input captured at the rising edge
    always @(posedge i_clk) begin
        o_ready_q <= 1'b0;
        if (i_rst_n && i_valid && o_ready) begin
            t_item it;
            it.op = t_op'(i_operation); it.key = i_entry_key; it.hits = i_wanted_hits;
            it.comp[0] = i_comp_x; it.comp[1] = i_comp_y; it.comp[2] = i_comp_z;
            it.comp[3] = i_comp_w; it.comp[4] = i_comp_v; it.comp[5] = i_comp_u;
            it.comp[6] = i_comp_t;
            predict_item(it);
            o_ready_q <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_result exp_r;
            n_results++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d key=%0h", $realtime, o_status,
                         o_hit_key);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status == ST_DONE && o_hit_distance != 0) n_hits++;
                if (o_status !== exp_r.status || o_hit_key !== exp_r.key ||
                    o_hit_distance !== exp_r.hit_dist || o_hit_rank !== exp_r.rank ||
                    o_last !== exp_r.last) begin
                    $display("%0t: mismatch expected st=%0d key=%0h dist=%0h rank=%0d last=%0b",
                             $realtime, exp_r.status, exp_r.key, exp_r.hit_dist, exp_r.rank,
                             exp_r.last);
                    $display("%0t:          actual   st=%0d key=%0h dist=%0h rank=%0d last=%0b",
                             $realtime, o_status, o_hit_key, o_hit_distance, o_hit_rank,
                             o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, extremes, ties, every operation
        queue_item(OP_SEARCH, 32'h0, 17'd0, 4'd8);
        queue_item(OP_REMOVE, 32'h5, 17'd0, 4'd0);
        queue_item(OP_INDEX, 32'h0, 17'd0, 4'd0);
        queue_item(OP_INDEX, 32'hFFFFFFFF, OneQ16, 4'd0);
        queue_item(OP_INDEX, 32'h1, 17'h1FFFF, 4'd0);      // saturates to one
        queue_item(OP_INDEX, 32'h2, 17'd0, 4'd0);          // tie with key 0
        queue_item(OP_INDEX, 32'h0, 17'd32768, 4'd0);      // update in place
        queue_item(OP_SEARCH, 32'h0, 17'd0, 4'd15);
        queue_item(OP_SEARCH, 32'h0, OneQ16, 4'd1);
        queue_item(OP_SEARCH, 32'h0, 17'd16384, 4'd0);     // zero hits wanted
        queue_item(OP_NONE, 32'h1, 17'd1, 4'd3);
        queue_item(OP_REMOVE, 32'h0, 17'd0, 4'd0);         // last entry moves in
        queue_item(OP_REMOVE, 32'h0, 17'd0, 4'd0);
        queue_item(OP_SEARCH, 32'hABCD, 17'd0, 4'd8);
        drain();
        write_thresh(35'd0);
        queue_item(OP_SEARCH, 32'h0, 17'd0, 4'd4);         // exact match only
        queue_item(OP_SEARCH, 32'h0, 17'd1, 4'd4);         // nothing within zero
        drain();

        // random phases across several thresholds
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_thresh(35'h7FFFFFFFF);
                1: write_thresh({3'($urandom_range(0, 6)), $urandom});
                2: write_thresh(35'd1 << $urandom_range(20, 33));
                default: write_thresh(ThreshReset);
            endcase
            for (int n = 0; n < 25; n++) begin
                int r;
                r = $urandom_range(0, 19);
                pending_items.push_back(rand_item(r < 8 ? OP_INDEX : r < 11 ? OP_REMOVE :
                                                  r < 19 ? OP_SEARCH : OP_NONE, 12));
            end
            drain();
        end
        $display("Covered index, update, remove, search and no-op items over five thresholds.");
        $display("Checked %0d results, %0d of them nonzero-distance hits.", n_results, n_hits);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
